// File: hdl/tensor_index_gather_addresses_macros.svh
// Assertion macros shared by the gather address generator RTL.
`ifndef TENSOR_INDEX_GATHER_ADDRESSES_MACROS_SVH
`define TENSOR_INDEX_GATHER_ADDRESSES_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition must hold at every edge out of reset.
`define TIGA_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("tiga: invariant violated");
// Consequent must hold in the same cycle as the antecedent.
`define TIGA_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tiga: implication violated");
// Consequent must hold in the cycle after the antecedent.
`define TIGA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tiga: next-cycle implication violated");
`else
`define TIGA_ASSERT_ALWAYS(lbl, ck, rn, expr)
`define TIGA_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define TIGA_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: hdl/tiga_pkg.sv
// Shared types and constants of the gather address generator.
`default_nettype none
package tiga_pkg;

  localparam int SIZE_W     = 9;
  localparam int COUNT_W    = 7;
  localparam int KIND_W     = 2;
  localparam int DIM_W      = 2;
  localparam int SLOT_W     = 6;
  localparam int COORD_W    = 8;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // register map: sizes first, then list counts
  localparam int CFG_DIMS       = 4;
  localparam int CFG_SIZE_BASE  = 0;
  localparam int CFG_COUNT_BASE = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_EMIT    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef struct packed {
    logic emit;
    logic restart;
  } odo_ctrl_t;

  typedef struct packed {
    logic valid;
    logic addr_valid;
    logic last;
    logic rejected;
  } side_t;

endpackage
`default_nettype wire

// File: hdl/tiga_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tiga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hdl/tiga_odometer.sv
// Odometer over the chosen-coordinate lists, last dimension fastest.
`default_nettype none
`include "tensor_index_gather_addresses_macros.svh"
module tiga_odometer #(
  parameter int NUM_DIMS   = 4,
  parameter int LIST_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tiga_pkg::odo_ctrl_t               ctrl,
  input  wire logic [tiga_pkg::COUNT_W-1:0]      count [NUM_DIMS],
  output logic      [$clog2(LIST_DEPTH)-1:0]     digit [NUM_DIMS],
  output logic                                   last
);
  import tiga_pkg::*;

  localparam int DW    = $clog2(LIST_DEPTH);
  localparam int EW    = $clog2(LIST_DEPTH + 1);
  localparam int CMPW  = (COUNT_W > EW) ? COUNT_W : EW;

  logic [DW-1:0]       digit_r   [NUM_DIMS];
  logic [DW-1:0]       digit_nxt [NUM_DIMS];
  logic [CMPW-1:0]     eff       [NUM_DIMS];
  logic [CMPW-1:0]     inc       [NUM_DIMS];
  logic [NUM_DIMS-1:0] wrap;
  logic                digits_zero;

  // clamp each count into one..LIST_DEPTH, flag digits that roll over
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (count[d] == '0) begin
        eff[d] = CMPW'(1);
      end else if (CMPW'(count[d]) > CMPW'(LIST_DEPTH)) begin
        eff[d] = CMPW'(LIST_DEPTH);
      end else begin
        eff[d] = CMPW'(count[d]);
      end
      inc[d]  = CMPW'(digit_r[d]) + CMPW'(1);
      wrap[d] = (inc[d] >= eff[d]);
    end
  end

  assign last = &wrap;

  always_comb begin
    logic carry;
    carry     = 1'b1;
    digit_nxt = digit_r;
    if (ctrl.restart) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        digit_nxt[d] = '0;
      end
    end else if (ctrl.emit) begin
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
        if (carry) begin
          if (wrap[d]) begin
            digit_nxt[d] = '0;
          end else begin
            digit_nxt[d] = inc[d][DW-1:0];
            carry        = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        digit_r[d] <= '0;
      end
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

  always_comb begin
    digits_zero = 1'b1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (digit_r[d] != '0) begin
        digits_zero = 1'b0;
      end
    end
  end

  `TIGA_ASSERT_NEXT(a_restart_clears, clk, rst_n, ctrl.restart, digits_zero)
  `TIGA_ASSERT_NEXT(a_last_wraps, clk, rst_n, ctrl.emit && !ctrl.restart && last, digits_zero)

endmodule
`default_nettype wire

// File: hdl/tiga_addr_pipe.sv
// Horner-form stride sum: one stride-sum stage per dimension, a multiply-add in all but the first.
`default_nettype none
module tiga_addr_pipe #(
  parameter int NUM_DIMS   = 4,
  parameter int COORD_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tiga_pkg::side_t               side_in,
  input  wire logic [COORD_BITS-1:0]         coord_in [NUM_DIMS],
  input  wire logic [tiga_pkg::SIZE_W-1:0]   size [NUM_DIMS],
  output tiga_pkg::side_t                    side_out,
  output logic      [tiga_pkg::ADDR_W-1:0]   acc_out
);
  import tiga_pkg::*;

  localparam int MULW = ADDR_W + SIZE_W;

  side_t             side_r  [NUM_DIMS];
  logic [ADDR_W-1:0] acc_r   [NUM_DIMS];
  logic [COORD_BITS-1:0] coord_r [NUM_DIMS][NUM_DIMS];

  // stage s holds c0*s1*..*ss + .. + cs, i.e. the partial sum up to dimension s
  for (genvar s = 0; s < NUM_DIMS; s++) begin : g_stage
    logic [ADDR_W-1:0] acc_nxt;
    if (s == 0) begin : g_first
      assign acc_nxt = ADDR_W'(coord_in[0]);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_r[s] <= '0;
        end else begin
          side_r[s] <= side_in;
        end
        acc_r[s]   <= acc_nxt;
        coord_r[s] <= coord_in;
      end
    end else begin : g_rest
      logic [MULW-1:0] prod;
      assign prod    = MULW'(acc_r[s-1]) * MULW'(size[s]);
      assign acc_nxt = prod[ADDR_W-1:0] + ADDR_W'(coord_r[s-1][s]);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_r[s] <= '0;
        end else begin
          side_r[s] <= side_r[s-1];
        end
        acc_r[s]   <= acc_nxt;
        coord_r[s] <= coord_r[s-1];
      end
    end
  end

  assign side_out = side_r[NUM_DIMS-1];
  assign acc_out  = acc_r[NUM_DIMS-1];

endmodule
`default_nettype wire

// File: hdl/tensor_index_gather_addresses.sv
// Top level of the multidimensional gather address generator.
//
//  port group   direction  handshake              contents
//  in_*         in         start / busy           kind, dim, slot, coordinate
//  out_*        out        out_valid strobe       address, address_valid, last, rejected
//  cfg_*        in         cfg_we, no wait        cfg_index selects size/count register
//
// One word is taken per cycle while busy is low; each word yields exactly one
// result word after it passes the input register, the list RAM read, then one
// stride-sum stage per dimension (a multiply-add in all but the first).
// busy is high only while rst_n is low; reset clears the odometer, the
// pipeline strobes and the registers (sizes and counts to one). The coordinate
// lists are not cleared. The receiver cannot stall, so nothing ever backs up.
`default_nettype none
`include "tensor_index_gather_addresses_macros.svh"
module tensor_index_gather_addresses #(
  parameter int NUM_DIMS   = 4,
  parameter int LIST_DEPTH = 64,
  parameter int COORD_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [tiga_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [tiga_pkg::DIM_W-1:0]         in_dim,
  input  wire logic [tiga_pkg::SLOT_W-1:0]        in_slot,
  input  wire logic [tiga_pkg::COORD_W-1:0]       in_coordinate,
  output logic                                    out_valid,
  output logic      [tiga_pkg::ADDR_W-1:0]        out_address,
  output logic                                    out_address_valid,
  output logic                                    out_last,
  output logic                                    out_rejected,
  input  wire logic                               cfg_we,
  input  wire logic [tiga_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tiga_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tiga_pkg::*;

  localparam int AW  = $clog2(LIST_DEPTH);
  localparam int LAT = NUM_DIMS + 2;

  // configuration registers
  logic [SIZE_W-1:0]  size_r  [NUM_DIMS];
  logic [COUNT_W-1:0] count_r [NUM_DIMS];

  // input register
  logic               in_valid_r;
  logic [KIND_W-1:0]  in_kind_r;
  logic [DIM_W-1:0]   in_dim_r;
  logic [SLOT_W-1:0]  in_slot_r;
  logic [COORD_W-1:0] in_coord_r;

  logic               accept;
  logic               is_load;
  logic               is_emit;
  logic               is_restart;
  logic               load_ok;
  logic               reject;
  logic [SIZE_W-1:0]  sel_size;
  logic [NUM_DIMS-1:0] ram_we;

  odo_ctrl_t          odo_ctrl;
  logic [AW-1:0]      digit [NUM_DIMS];
  logic               odo_last;

  side_t              side_nxt;
  side_t              side_s1_r;
  logic [COORD_BITS-1:0] ram_rdata [NUM_DIMS];

  side_t              pipe_side;
  logic [ADDR_W-1:0]  pipe_acc;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Registers: index CFG_SIZE_BASE + d is a size, CFG_COUNT_BASE + d a count.
  // Dimensions past the register map keep their reset value of one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        size_r[d]  <= SIZE_W'(1);
        count_r[d] <= COUNT_W'(1);
      end
    end else if (cfg_we) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        if (d < CFG_DIMS && cfg_index == CFG_IDX_W'(CFG_SIZE_BASE + d)) begin
          size_r[d] <= cfg_data[SIZE_W-1:0];
        end
        if (d < CFG_DIMS && cfg_index == CFG_IDX_W'(CFG_COUNT_BASE + d)) begin
          count_r[d] <= cfg_data[COUNT_W-1:0];
        end
      end
    end
  end

  // Capture the word; payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
    in_kind_r  <= in_kind;
    in_dim_r   <= in_dim;
    in_slot_r  <= in_slot;
    in_coord_r <= in_coordinate;
  end

  always_comb begin
    is_load    = 1'b0;
    is_emit    = 1'b0;
    is_restart = 1'b0;
    case (kind_t'(in_kind_r))
      KIND_LOAD:    is_load    = in_valid_r;
      KIND_EMIT:    is_emit    = in_valid_r;
      KIND_RESTART: is_restart = in_valid_r;
      default:      ;  // unused code: drop the word, answer all zero
    endcase
  end

  // Pick the size of the addressed dimension for the range check.
  always_comb begin
    sel_size = SIZE_W'(1);
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (d < (1 << DIM_W) && in_dim_r == DIM_W'(d)) begin
        sel_size = size_r[d];
      end
    end
  end

  // A load outside the list storage is ignored without a flag.
  assign load_ok = is_load && (32'(in_dim_r) < NUM_DIMS) && (32'(in_slot_r) < LIST_DEPTH);
  assign reject  = load_ok && (SIZE_W'(in_coord_r) >= sel_size);

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      ram_we[d] = load_ok && !reject && (32'(in_dim_r) == d);
    end
  end

  // One list RAM per dimension, so every dimension reads its digit each cycle.
  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_list
    tiga_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (LIST_DEPTH)
    ) u_list (
      .clk   (clk),
      .we    (ram_we[d]),
      .waddr (AW'(in_slot_r)),
      .wdata (COORD_BITS'(in_coord_r)),
      .raddr (digit[d]),
      .rdata (ram_rdata[d])
    );
  end

  assign odo_ctrl.emit    = is_emit;
  assign odo_ctrl.restart = is_restart;

  tiga_odometer #(
    .NUM_DIMS   (NUM_DIMS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_odometer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (odo_ctrl),
    .count (count_r),
    .digit (digit),
    .last  (odo_last)
  );

  // Sideband for the word, aligned with the RAM read data.
  always_comb begin
    side_nxt.valid      = in_valid_r;
    side_nxt.addr_valid = is_emit;
    side_nxt.last       = is_emit && odo_last;
    side_nxt.rejected   = reject;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_s1_r <= '0;
    end else begin
      side_s1_r <= side_nxt;
    end
  end

  tiga_addr_pipe #(
    .NUM_DIMS   (NUM_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_addr_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_in  (side_s1_r),
    .coord_in (ram_rdata),
    .size     (size_r),
    .side_out (pipe_side),
    .acc_out  (pipe_acc)
  );

  // Non-address words report a zero address.
  assign out_valid         = pipe_side.valid;
  assign out_address_valid = pipe_side.addr_valid;
  assign out_last          = pipe_side.last;
  assign out_rejected      = pipe_side.rejected;
  assign out_address       = pipe_side.addr_valid ? pipe_acc : '0;

  `TIGA_ASSERT_ALWAYS(a_fixed_latency, clk, rst_n, out_valid == $past(accept, LAT))
  `TIGA_ASSERT_IMPLY(a_reject_from_load, clk, rst_n, out_rejected, $past(accept && in_kind == KIND_LOAD, LAT))
  `TIGA_ASSERT_IMPLY(a_addr_from_emit, clk, rst_n, out_address_valid, $past(accept && in_kind == KIND_EMIT, LAT))

endmodule
`default_nettype wire
